// File: src/jcs_pkg.sv
// Shared types and constants for the JSONC comment stripper.
package jcs_pkg;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [6:0] {
		M_NORMAL     = 7'b0000001,
		M_SLASH      = 7'b0000010,
		M_LINE       = 7'b0000100,
		M_BLOCK      = 7'b0001000,
		M_BLOCK_STAR = 7'b0010000,
		M_STRING     = 7'b0100000,
		M_STRING_ESC = 7'b1000000
	} mode_t;

	// One queued command: one or two results caused by a single input byte.
	typedef struct packed {
		logic [7:0] byte0;
		logic       bv0;
		logic [7:0] byte1;
		logic       two;
		logic       eot;
	} entry_t;

endpackage

// File: src/jsonc_comment_stripper.sv
// JSONC comment stripper top level.
// Path: an accepted byte is written into the command queue, then loaded into the output register.
// Throughput: one input byte per cycle while in_stall is low; an item with two results
// holds the output sequencer for both, absorbed by a four-entry queue until it fills.
// Reset (arst_n low) returns the scan mode to normal text and empties queue and output.
module jsonc_comment_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_text
);

	jcs_pkg::entry_t wr_entry;
	jcs_pkg::entry_t rd_entry;
	logic            q_full;
	logic            q_empty;
	logic            q_push;
	logic            q_pop;

	jcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (wr_entry)
	);

	jcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.empty    (q_empty)
	);

	jcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_entry     (rd_entry),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.end_of_text (end_of_text)
	);

endmodule

// File: src/jcs_front.sv
// Front end: scan-mode state machine that classifies each byte and queues a result command when it yields output.
module jcs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             q_full,
	output logic             q_push,
	output jcs_pkg::entry_t  q_entry
);

	jcs_pkg::mode_t mode_q;
	jcs_pkg::mode_t mode_nxt;
	logic           accept;
	logic           emit_slash;
	logic           emit_b;
	logic [1:0]     cnt_a;
	logic [1:0]     cnt;
	logic [7:0]     pos0;
	logic [7:0]     pos1;
	logic           bv0;
	logic           end_slash;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		mode_nxt   = mode_q;
		emit_slash = 1'b0;
		emit_b     = 1'b0;
		case (mode_q)
			jcs_pkg::M_SLASH: begin
				if (in_byte == jcs_pkg::CH_SLASH) begin
					mode_nxt = jcs_pkg::M_LINE;
				end else if (in_byte == jcs_pkg::CH_STAR) begin
					mode_nxt = jcs_pkg::M_BLOCK;
				end else begin
					emit_slash = 1'b1;
					emit_b     = 1'b1;
					mode_nxt   = (in_byte == jcs_pkg::CH_QUOTE) ? jcs_pkg::M_STRING
					                                            : jcs_pkg::M_NORMAL;
				end
			end
			jcs_pkg::M_LINE: begin
				if (in_byte == jcs_pkg::CH_NEWLINE) begin
					emit_b   = 1'b1;
					mode_nxt = jcs_pkg::M_NORMAL;
				end
			end
			jcs_pkg::M_BLOCK: begin
				if (in_byte == jcs_pkg::CH_STAR) begin
					mode_nxt = jcs_pkg::M_BLOCK_STAR;
				end
			end
			jcs_pkg::M_BLOCK_STAR: begin
				if (in_byte == jcs_pkg::CH_SLASH) begin
					mode_nxt = jcs_pkg::M_NORMAL;
				end else if (in_byte != jcs_pkg::CH_STAR) begin
					mode_nxt = jcs_pkg::M_BLOCK;
				end
			end
			jcs_pkg::M_STRING: begin
				emit_b = 1'b1;
				if (in_byte == jcs_pkg::CH_BACKSLASH) begin
					mode_nxt = jcs_pkg::M_STRING_ESC;
				end else if (in_byte == jcs_pkg::CH_QUOTE) begin
					mode_nxt = jcs_pkg::M_NORMAL;
				end
			end
			jcs_pkg::M_STRING_ESC: begin
				emit_b   = 1'b1;
				mode_nxt = jcs_pkg::M_STRING;
			end
			default: begin
				if (in_byte == jcs_pkg::CH_SLASH) begin
					mode_nxt = jcs_pkg::M_SLASH;
				end else begin
					emit_b   = 1'b1;
					mode_nxt = (in_byte == jcs_pkg::CH_QUOTE) ? jcs_pkg::M_STRING
					                                          : jcs_pkg::M_NORMAL;
				end
			end
		endcase
	end

	always_comb begin
		cnt_a     = {1'b0, emit_slash} + {1'b0, emit_b};
		pos0      = emit_slash ? jcs_pkg::CH_SLASH : in_byte;
		pos1      = in_byte;
		bv0       = 1'b1;
		cnt       = cnt_a;
		end_slash = in_last && (mode_nxt == jcs_pkg::M_SLASH);
		if (end_slash) begin
			if (cnt_a == 2'd0) begin
				pos0 = jcs_pkg::CH_SLASH;
			end else begin
				pos1 = jcs_pkg::CH_SLASH;
			end
			cnt = cnt_a + 2'd1;
		end
		if (in_last && cnt == 2'd0) begin
			pos0 = 8'h00;
			bv0  = 1'b0;
			cnt  = 2'd1;
		end
	end

	assign q_push        = accept && (cnt != 2'd0);
	assign q_entry.byte0 = pos0;
	assign q_entry.bv0   = bv0;
	assign q_entry.byte1 = pos1;
	assign q_entry.two   = (cnt == 2'd2);
	assign q_entry.eot   = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jcs_pkg::M_NORMAL;
		end else if (accept) begin
			mode_q <= in_last ? jcs_pkg::M_NORMAL : mode_nxt;
		end
	end

endmodule

// File: src/jcs_queue.sv
// Command queue between the classifier and the output sequencer.
module jcs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jcs_pkg::entry_t  wr_entry,
	output logic             full,
	input  logic             pop,
	output jcs_pkg::entry_t  rd_entry,
	output logic             empty
);

	jcs_pkg::entry_t                 mem_q [jcs_pkg::QDEPTH];
	logic [jcs_pkg::QAW-1:0]         wr_ptr_q;
	logic [jcs_pkg::QAW-1:0]         rd_ptr_q;
	logic [jcs_pkg::QCW-1:0]         cnt_q;

	assign full     = (cnt_q == jcs_pkg::QCW'(jcs_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from empty queue");

endmodule

// File: src/jcs_back.sv
// Back end: expands queued commands into result transactions through an output register.
module jcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jcs_pkg::entry_t  q_entry,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             end_of_text
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       eot_q;
	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       pend_eot_q;
	logic       load;

	assign load  = !out_valid_q || !out_stall;
	assign q_pop = load && !pend_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= q_entry.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_byte_q   <= pend_byte_q;
				byte_valid_q <= 1'b1;
				eot_q        <= pend_eot_q;
			end else if (!q_empty) begin
				out_byte_q   <= q_entry.byte0;
				byte_valid_q <= q_entry.bv0;
				eot_q        <= q_entry.eot && !q_entry.two;
				pend_byte_q  <= q_entry.byte1;
				pend_eot_q   <= q_entry.eot;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_valid  = byte_valid_q;
	assign end_of_text = eot_q;

	a_pend_has_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q) else $error("second result pending without first");
	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !byte_valid_q) |-> eot_q) else $error("bare marker without end");
	a_pend_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !q_pop) else $error("queue popped while second result pending");

endmodule

// File: tb/jsonc_comment_stripper_tb.sv
// Self-checking testbench for the JSONC comment stripper: predicted byte stream vs DUT output.
`timescale 1ns / 100ps

module jsonc_comment_stripper_tb;

	localparam int N_ITEMS        = 1550;
	localparam int DRAIN_INTERVAL = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_REPORTS    = 10;

	typedef logic [7:0] text_t[$];

	typedef struct packed {
		logic [7:0] ch;
		logic       bv;
		logic       eot;
	} kept_t;

	class strip_scoreboard;
		jcs_pkg::mode_t scan;
		kept_t kept_q[$];
		kept_t step_q[$];
		int    mismatch_count;

		function new();
			scan = jcs_pkg::M_NORMAL;
			mismatch_count = 0;
		endfunction

		function int pending();
			return kept_q.size();
		endfunction

		function void keep_byte(logic [7:0] b);
			step_q.push_back('{ch: b, bv: 1'b1, eot: 1'b0});
		endfunction

		function void text_byte(logic [7:0] b);
			if (b == jcs_pkg::CH_QUOTE) begin
				scan = jcs_pkg::M_STRING;
				keep_byte(b);
			end else if (b == jcs_pkg::CH_SLASH) begin
				scan = jcs_pkg::M_SLASH;
			end else begin
				scan = jcs_pkg::M_NORMAL;
				keep_byte(b);
			end
		endfunction

		// Works out the bytes kept for one accepted input transaction.
		function void note_byte(logic [7:0] b, logic last);
			kept_t tail;
			step_q.delete();
			case (scan)
				jcs_pkg::M_SLASH: begin
					if (b == jcs_pkg::CH_SLASH)
						scan = jcs_pkg::M_LINE;
					else if (b == jcs_pkg::CH_STAR)
						scan = jcs_pkg::M_BLOCK;
					else begin
						keep_byte(jcs_pkg::CH_SLASH);
						text_byte(b);
					end
				end
				jcs_pkg::M_LINE: begin
					if (b == jcs_pkg::CH_NEWLINE) begin
						scan = jcs_pkg::M_NORMAL;
						keep_byte(b);
					end
				end
				jcs_pkg::M_BLOCK: begin
					if (b == jcs_pkg::CH_STAR)
						scan = jcs_pkg::M_BLOCK_STAR;
				end
				jcs_pkg::M_BLOCK_STAR: begin
					if (b == jcs_pkg::CH_SLASH)
						scan = jcs_pkg::M_NORMAL;
					else if (b != jcs_pkg::CH_STAR)
						scan = jcs_pkg::M_BLOCK;
				end
				jcs_pkg::M_STRING: begin
					keep_byte(b);
					if (b == jcs_pkg::CH_BACKSLASH)
						scan = jcs_pkg::M_STRING_ESC;
					else if (b == jcs_pkg::CH_QUOTE)
						scan = jcs_pkg::M_NORMAL;
				end
				jcs_pkg::M_STRING_ESC: begin
					keep_byte(b);
					scan = jcs_pkg::M_STRING;
				end
				default: text_byte(b);
			endcase
			if (last) begin
				if (scan == jcs_pkg::M_SLASH)
					keep_byte(jcs_pkg::CH_SLASH);
				if (step_q.size() == 0)
					step_q.push_back('{ch: 8'h00, bv: 1'b0, eot: 1'b0});
				tail = step_q.pop_back();
				tail.eot = 1'b1;
				step_q.push_back(tail);
				scan = jcs_pkg::M_NORMAL;
			end
			foreach (step_q[i])
				kept_q.push_back(step_q[i]);
		endfunction

		function void check_result(logic [7:0] b, logic bv, logic eot);
			kept_t want;
			if (kept_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result byte=%02h bv=%0b eot=%0b",
						$realtime, b, bv, eot);
				return;
			end
			want = kept_q.pop_front();
			if (want.ch !== b || want.bv !== bv || want.eot !== eot) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: exp byte=%02h bv=%0b eot=%0b, got byte=%02h bv=%0b eot=%0b",
						$realtime, want.ch, want.bv, want.eot, b, bv, eot);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_text;

	strip_scoreboard sb = new();

	int burst_left = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int rx_phase_left = 0;
	int rx_style = 0;
	int rx_tick = 0;

	jsonc_comment_stripper u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.end_of_text(end_of_text)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (rx_phase_left == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_phase_left = $urandom_range(20, 200);
		end
		rx_phase_left--;
		rx_tick++;
		case (rx_style)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((rx_tick % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(in_byte, in_last);
			if (out_valid && !out_stall)
				sb.check_result(out_byte, byte_valid, end_of_text);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("Verification failed");
		$finish;
	end

	function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] b);
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == a || c == b)
			c = 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 6))
			0: return jcs_pkg::CH_SLASH;
			1: return jcs_pkg::CH_STAR;
			2: return jcs_pkg::CH_QUOTE;
			3: return jcs_pkg::CH_BACKSLASH;
			4: return jcs_pkg::CH_NEWLINE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed JSONC fragments; some texts are plain noise or end broken.
	function automatic text_t build_text();
		text_t t;
		string js;
		js = "{}[]:,0123456789-.";
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 20))
				t.push_back(noise_byte());
			return t;
		end
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 6))
				0: repeat ($urandom_range(1, 5))
					t.push_back(any_but(jcs_pkg::CH_SLASH, jcs_pkg::CH_QUOTE));
				1: begin
					t.push_back(jcs_pkg::CH_QUOTE);
					repeat ($urandom_range(0, 6)) begin
						if ($urandom_range(0, 3) == 0) begin
							t.push_back(jcs_pkg::CH_BACKSLASH);
							t.push_back(noise_byte());
						end else
							t.push_back(any_but(jcs_pkg::CH_QUOTE, jcs_pkg::CH_BACKSLASH));
					end
					t.push_back(jcs_pkg::CH_QUOTE);
				end
				2: begin
					t.push_back(jcs_pkg::CH_SLASH);
					t.push_back(jcs_pkg::CH_SLASH);
					repeat ($urandom_range(0, 6))
						t.push_back(any_but(jcs_pkg::CH_NEWLINE, jcs_pkg::CH_NEWLINE));
					t.push_back(jcs_pkg::CH_NEWLINE);
				end
				3: begin
					t.push_back(jcs_pkg::CH_SLASH);
					t.push_back(jcs_pkg::CH_STAR);
					if ($urandom_range(0, 3) == 0)
						t.push_back(jcs_pkg::CH_SLASH);
					repeat ($urandom_range(0, 6))
						t.push_back(($urandom_range(0, 2) == 0) ? jcs_pkg::CH_STAR :
							any_but(jcs_pkg::CH_STAR, jcs_pkg::CH_SLASH));
					repeat ($urandom_range(1, 3))
						t.push_back(jcs_pkg::CH_STAR);
					t.push_back(jcs_pkg::CH_SLASH);
				end
				4: begin
					t.push_back(jcs_pkg::CH_SLASH);
					t.push_back(any_but(jcs_pkg::CH_SLASH, jcs_pkg::CH_STAR));
				end
				5: t.push_back(($urandom_range(0, 1) == 0) ? jcs_pkg::CH_NEWLINE : 8'h20);
				default: repeat ($urandom_range(1, 4))
					t.push_back(js[$urandom_range(0, js.len() - 1)]);
			endcase
		end
		case ($urandom_range(0, 9))
			0: t.push_back(jcs_pkg::CH_SLASH);
			1: begin
				t.push_back(jcs_pkg::CH_SLASH);
				t.push_back(jcs_pkg::CH_STAR);
				t.push_back(noise_byte());
			end
			2: begin
				t.push_back(jcs_pkg::CH_QUOTE);
				t.push_back(jcs_pkg::CH_BACKSLASH);
			end
			3: begin
				t.push_back(jcs_pkg::CH_SLASH);
				t.push_back(jcs_pkg::CH_SLASH);
				t.push_back(any_but(jcs_pkg::CH_NEWLINE, jcs_pkg::CH_NEWLINE));
			end
			default: ;
		endcase
		return t;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		burst_left--;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic send_text(input text_t t);
		foreach (t[i])
			send_byte(t[i], (i == t.size() - 1));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int next_drain;
		next_drain = DRAIN_INTERVAL;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text('{8'h00, 8'hFF, jcs_pkg::CH_SLASH});
		send_text('{jcs_pkg::CH_QUOTE, jcs_pkg::CH_BACKSLASH});
		send_text('{jcs_pkg::CH_SLASH, jcs_pkg::CH_SLASH, 8'h78, jcs_pkg::CH_NEWLINE,
			jcs_pkg::CH_SLASH, jcs_pkg::CH_STAR, jcs_pkg::CH_SLASH, jcs_pkg::CH_STAR,
			jcs_pkg::CH_STAR, jcs_pkg::CH_SLASH, 8'h7A});
		send_text('{jcs_pkg::CH_SLASH, jcs_pkg::CH_STAR, 8'h71});
		send_text('{jcs_pkg::CH_QUOTE, jcs_pkg::CH_SLASH, jcs_pkg::CH_SLASH,
			jcs_pkg::CH_QUOTE, jcs_pkg::CH_SLASH, 8'h61});
		wait_drained();

		while (items_sent < N_ITEMS) begin
			send_text(build_text());
			if (items_sent >= next_drain) begin
				wait_drained();
				next_drain += DRAIN_INTERVAL;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
